@@ hw/rtl/tfpc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfpc_pkg
// Types, codes and reset values shared by the thermal fan PWM controller.
// ----------------------------------------------------------------------------
package tfpc_pkg;

    typedef enum logic [1:0] {
        PHASE_NORMAL = 2'd0,
        PHASE_FAILED = 2'd1
    } phase_t;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_READ_ERR = 2'd1;
    localparam logic [1:0] STATUS_FAULT    = 2'd2;

    localparam logic [2:0] REG_CURVE_TEMP_LOW   = 3'd0;
    localparam logic [2:0] REG_CURVE_PWM_MIN    = 3'd1;
    localparam logic [2:0] REG_CURVE_PWM_MAX    = 3'd2;
    localparam logic [2:0] REG_CURVE_GAIN       = 3'd3;
    localparam logic [2:0] REG_HYSTERESIS_DEG   = 3'd4;
    localparam logic [2:0] REG_READ_ERROR_LIMIT = 3'd5;
    localparam logic [2:0] REG_SWITCH_TEMP_REF  = 3'd6;
    localparam logic [2:0] REG_FAULT_PWM        = 3'd7;

    localparam logic [7:0] RST_CURVE_TEMP_LOW   = 8'd35;
    localparam logic [7:0] RST_CURVE_PWM_MIN    = 8'd122;
    localparam logic [7:0] RST_CURVE_PWM_MAX    = 8'd255;
    localparam logic [7:0] RST_CURVE_GAIN       = 8'd12;
    localparam logic [3:0] RST_HYSTERESIS_DEG   = 4'd2;
    localparam logic [3:0] RST_READ_ERROR_LIMIT = 4'd5;
    localparam logic [7:0] RST_SWITCH_TEMP_REF  = 8'd63;
    localparam logic [7:0] RST_FAULT_PWM        = 8'd255;

    // temperatures are two's complement bit patterns
    typedef struct packed {
        logic [7:0] curve_temp_low;
        logic [7:0] curve_pwm_min;
        logic [7:0] curve_pwm_max;
        logic [7:0] curve_gain;
        logic [3:0] hysteresis_deg;
        logic [3:0] read_error_limit;
        logic [7:0] switch_temp_ref;
        logic [7:0] fault_pwm;
    } cfg_t;

    typedef struct packed {
        logic [7:0] air_temp;
        logic       air_temp_ok;
        logic [7:0] chip_temp;
        logic       chip_temp_ok;
        logic       fan_bad;
        logic       psu_bad;
    } item_t;

    typedef struct packed {
        logic       started;
        logic [7:0] kept_air_temp;
        logic [7:0] kept_chip_temp;
        logic [7:0] last_pwm;
        logic [3:0] read_error_count;
        phase_t     fault_phase;
    } state_t;

    typedef struct packed {
        logic       pwm_write;
        logic [7:0] pwm_value;
        logic [1:0] status;
    } result_t;

endpackage

@@ hw/rtl/thermal_fan_pwm_controller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thermal_fan_pwm_controller
// Fan PWM command from air and switch chip temperatures, with read error
// counting, fault override and recovery.
// ----------------------------------------------------------------------------
//  channel   handshake                payload
//  in        in_valid / in_ready      air_temp, air_temp_ok, chip_temp,
//                                     chip_temp_ok, fan_bad, psu_bad
//  out       out_valid / out_ready    pwm_write, pwm_value, fan_percent, status
//  cfg       cfg_we                   cfg_index, cfg_data
//
//  One request per cycle sustained while out_ready is high; a request moves
//  from the input register into the result register once that one is free.
//  The input register, the decision logic and the result register form one
//  pass; controller state updates as the result register loads.
//  A stalled result holds in the result register while one more request waits
//  in the input register; in_ready drops only when both are full.
//  rst_n clears state, configuration to defaults and both valid flags.
// ----------------------------------------------------------------------------
module thermal_fan_pwm_controller (
    input  logic       clk,
    input  logic       rst_n,

    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] air_temp,
    input  logic       air_temp_ok,
    input  logic [7:0] chip_temp,
    input  logic       chip_temp_ok,
    input  logic       fan_bad,
    input  logic       psu_bad,

    output logic       out_valid,
    input  logic       out_ready,
    output logic       pwm_write,
    output logic [7:0] pwm_value,
    output logic [6:0] fan_percent,
    output logic [1:0] status,

    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data
);
    import tfpc_pkg::*;

    // 100/255 scaled by 2^16, rounded up
    localparam logic [14:0] PCT_RECIP = 15'd25701;

    cfg_t    cfg_reg;
    state_t  state_reg;
    state_t  state_next;
    item_t   item_reg;
    logic    in_vld_reg;
    result_t calc_res;
    result_t out_reg;
    logic    out_vld_reg;
    logic    advance;
    logic [22:0] pct_prod;

    assign advance  = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.curve_temp_low   <= RST_CURVE_TEMP_LOW;
            cfg_reg.curve_pwm_min    <= RST_CURVE_PWM_MIN;
            cfg_reg.curve_pwm_max    <= RST_CURVE_PWM_MAX;
            cfg_reg.curve_gain       <= RST_CURVE_GAIN;
            cfg_reg.hysteresis_deg   <= RST_HYSTERESIS_DEG;
            cfg_reg.read_error_limit <= RST_READ_ERROR_LIMIT;
            cfg_reg.switch_temp_ref  <= RST_SWITCH_TEMP_REF;
            cfg_reg.fault_pwm        <= RST_FAULT_PWM;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CURVE_TEMP_LOW:   cfg_reg.curve_temp_low   <= cfg_data;
                REG_CURVE_PWM_MIN:    cfg_reg.curve_pwm_min    <= cfg_data;
                REG_CURVE_PWM_MAX:    cfg_reg.curve_pwm_max    <= cfg_data;
                REG_CURVE_GAIN:       cfg_reg.curve_gain       <= cfg_data;
                REG_HYSTERESIS_DEG:   cfg_reg.hysteresis_deg   <= cfg_data[3:0];
                REG_READ_ERROR_LIMIT: cfg_reg.read_error_limit <= cfg_data[3:0];
                REG_SWITCH_TEMP_REF:  cfg_reg.switch_temp_ref  <= cfg_data;
                REG_FAULT_PWM:        cfg_reg.fault_pwm        <= cfg_data;
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.air_temp     <= air_temp;
            item_reg.air_temp_ok  <= air_temp_ok;
            item_reg.chip_temp    <= chip_temp;
            item_reg.chip_temp_ok <= chip_temp_ok;
            item_reg.fan_bad      <= fan_bad;
            item_reg.psu_bad      <= psu_bad;
        end
    end

    tfpc_calc u_calc (
        .cfg        (cfg_reg),
        .item       (item_reg),
        .state      (state_reg),
        .result     (calc_res),
        .state_next (state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.started          <= 1'b0;
            state_reg.kept_air_temp    <= 8'd0;
            state_reg.kept_chip_temp   <= 8'd0;
            state_reg.last_pwm         <= 8'd0;
            state_reg.read_error_count <= 4'd0;
            state_reg.fault_phase      <= PHASE_NORMAL;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= calc_res;
        end
    end

    // percent from the held duty; value is zero whenever no write is commanded
    assign pct_prod    = {15'b0, out_reg.pwm_value} * {8'b0, PCT_RECIP};
    assign fan_percent = pct_prod[22:16];

    assign out_valid = out_vld_reg;
    assign pwm_write = out_reg.pwm_write;
    assign pwm_value = out_reg.pwm_value;
    assign status    = out_reg.status;

endmodule

@@ hw/rtl/tfpc_calc.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfpc_calc
// Per-tick decision logic: curve, switch offset term, error and fault
// handling. Produces the result and the next controller state.
// ----------------------------------------------------------------------------
module tfpc_calc (
    input  tfpc_pkg::cfg_t    cfg,
    input  tfpc_pkg::item_t   item,
    input  tfpc_pkg::state_t  state,
    output tfpc_pkg::result_t result,
    output tfpc_pkg::state_t  state_next
);
    import tfpc_pkg::*;

    // reciprocals scaled by 2^16, rounded up; exact for magnitudes up to 255
    localparam logic [18:0] CHIP_STEP_RECIP = 19'd501351;  // 765/100
    localparam logic [16:0] CHIP_REF_RECIP  = 17'd66847;   // 102/100

    logic signed [8:0]  air_rel;
    logic signed [17:0] curve_prod;
    logic signed [18:0] curve_raw;
    logic signed [18:0] curve_clip;
    logic [7:0]         curve_pwm;

    logic [7:0]         chip_sel;
    logic signed [8:0]  chip_step;
    logic [8:0]         chip_step_neg;
    logic [7:0]         chip_step_mag;
    logic [26:0]        step_prod;
    logic signed [12:0] step_term;
    logic signed [8:0]  chip_ofs;
    logic [8:0]         chip_ofs_neg;
    logic [7:0]         chip_ofs_mag;
    logic [24:0]        ofs_prod;
    logic signed [12:0] ofs_term;
    logic signed [12:0] switch_term;
    logic signed [12:0] pick;
    logic [7:0]         new_pwm;

    logic signed [8:0]  air_move;
    logic [8:0]         air_move_neg;
    logic [7:0]         air_move_mag;
    logic               hold;
    logic [3:0]         err_count_inc;
    logic               recover;

    // clamped linear curve
    always_comb
    begin
        air_rel    = $signed({item.air_temp[7], item.air_temp})
                   - $signed({cfg.curve_temp_low[7], cfg.curve_temp_low});
        curve_prod = $signed({1'b0, cfg.curve_gain}) * air_rel;
        curve_raw  = $signed({curve_prod[17], curve_prod})
                   + $signed({11'b0, cfg.curve_pwm_min});
        curve_clip = curve_raw;
        if (curve_clip >= $signed({11'b0, cfg.curve_pwm_max}))
        begin
            curve_clip = $signed({11'b0, cfg.curve_pwm_max});
        end
        if (curve_clip <= $signed({11'b0, cfg.curve_pwm_min}))
        begin
            curve_clip = $signed({11'b0, cfg.curve_pwm_min});
        end
        curve_pwm = curve_clip[7:0];
    end

    // switch chip offset term, divisions truncate toward zero
    always_comb
    begin
        chip_sel      = item.chip_temp_ok ? item.chip_temp : state.kept_chip_temp;

        chip_step     = $signed({chip_sel[7], chip_sel})
                      - $signed({state.kept_chip_temp[7], state.kept_chip_temp});
        chip_step_neg = 9'(-chip_step);
        chip_step_mag = chip_step[8] ? chip_step_neg[7:0] : chip_step[7:0];
        step_prod     = {19'b0, chip_step_mag} * {8'b0, CHIP_STEP_RECIP};
        step_term     = $signed({2'b0, step_prod[26:16]});
        if (chip_step[8])
        begin
            step_term = -step_term;
        end

        chip_ofs      = $signed({chip_sel[7], chip_sel})
                      - $signed({cfg.switch_temp_ref[7], cfg.switch_temp_ref});
        chip_ofs_neg  = 9'(-chip_ofs);
        chip_ofs_mag  = chip_ofs[8] ? chip_ofs_neg[7:0] : chip_ofs[7:0];
        ofs_prod      = {17'b0, chip_ofs_mag} * {8'b0, CHIP_REF_RECIP};
        ofs_term      = $signed({4'b0, ofs_prod[24:16]});
        if (chip_ofs[8])
        begin
            ofs_term = -ofs_term;
        end

        switch_term = $signed({5'b0, state.last_pwm}) + step_term + ofs_term;
        pick = (switch_term > $signed({5'b0, curve_pwm})) ? switch_term
                                                          : $signed({5'b0, curve_pwm});
        if (pick < 13'sd0)
        begin
            new_pwm = 8'd0;
        end
        else if (pick > 13'sd255)
        begin
            new_pwm = 8'd255;
        end
        else
        begin
            new_pwm = pick[7:0];
        end
    end

    always_comb
    begin
        air_move      = $signed({item.air_temp[7], item.air_temp})
                      - $signed({state.kept_air_temp[7], state.kept_air_temp});
        air_move_neg  = 9'(-air_move);
        air_move_mag  = air_move[8] ? air_move_neg[7:0] : air_move[7:0];
        hold          = air_move_mag < {4'b0, cfg.hysteresis_deg};
        err_count_inc = (state.read_error_count == 4'd15) ? 4'd15
                                                          : state.read_error_count + 4'd1;
        recover       = state.fault_phase == PHASE_FAILED;

        state_next       = state;
        result.pwm_write = 1'b0;
        result.pwm_value = 8'd0;
        result.status    = STATUS_OK;

        if (!state.started)
        begin
            state_next.started        = 1'b1;
            state_next.kept_air_temp  = item.air_temp;
            state_next.kept_chip_temp = item.chip_temp;
            state_next.last_pwm       = curve_pwm;
            result.pwm_write          = 1'b1;
            result.pwm_value          = curve_pwm;
        end
        else if (!item.air_temp_ok)
        begin
            state_next.read_error_count = err_count_inc;
            result.status               = STATUS_READ_ERR;
            if (err_count_inc > cfg.read_error_limit)
            begin
                result.pwm_write = 1'b1;
                result.pwm_value = cfg.fault_pwm;
            end
        end
        else if (item.fan_bad || item.psu_bad)
        begin
            state_next.read_error_count = 4'd0;
            state_next.fault_phase      = PHASE_FAILED;
            result.pwm_write            = 1'b1;
            result.pwm_value            = cfg.fault_pwm;
            result.status               = STATUS_FAULT;
        end
        else
        begin
            state_next.read_error_count = 4'd0;
            state_next.fault_phase      = PHASE_NORMAL;
            if (!hold || recover)
            begin
                state_next.kept_air_temp  = item.air_temp;
                state_next.kept_chip_temp = chip_sel;
                state_next.last_pwm       = new_pwm;
                result.pwm_write          = 1'b1;
                result.pwm_value          = new_pwm;
            end
        end
    end

endmodule
